FILE: hdl/cmdarg_pkg.sv
// Package: constants, types and character codes for the command-line splitter.
package cmdarg_pkg;

    localparam int MAX_LINE = 2048;

    localparam int CH_W    = 16;
    localparam int SLASH_W = 11;
    localparam int ARGS_W  = 12;

    localparam int SLASH_CAP_I = ((MAX_LINE - 1) < 2047) ? (MAX_LINE - 1) : 2047;
    localparam int ARG_CAP_I   = (MAX_LINE < 2048) ? MAX_LINE : 2048;

    localparam logic [SLASH_W-1:0] SLASH_CAP = SLASH_W'(SLASH_CAP_I);
    localparam logic [ARGS_W-1:0]  ARG_CAP   = ARGS_W'(ARG_CAP_I);

    localparam logic [CH_W-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CH_W-1:0] CH_SLASH = 16'h005C;
    localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;

    localparam logic [1:0] QUOTE_LIT = 2'd2;

    typedef enum logic [2:0] {
        PH_START        = 3'd0,
        PH_FIRST_QUOTED = 3'd1,
        PH_FIRST_PLAIN  = 3'd2,
        PH_BETWEEN      = 3'd3,
        PH_ARG          = 3'd4
    } t_phase;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            is_zero;
        logic            is_blank;
        logic            is_quote;
        logic            is_slash;
    } t_item;

    typedef struct packed {
        logic [SLASH_W-1:0] slash_run;
        logic               has_char;
        logic [CH_W-1:0]    char_out;
        logic               end_arg;
        logic               end_line;
        logic [ARGS_W-1:0]  arg_count;
    } t_result;

endpackage

FILE: hdl/cmdarg_if.sv
// Interfaces: character input channel and argument result channel.
interface cmdarg_in_if;
    logic                      valid;
    logic                      ready;
    logic [cmdarg_pkg::CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface cmdarg_out_if;
    logic                           valid;
    logic                           ready;
    logic [cmdarg_pkg::SLASH_W-1:0] slash_run;
    logic                           has_char;
    logic [cmdarg_pkg::CH_W-1:0]    char_out;
    logic                           end_arg;
    logic                           end_line;
    logic [cmdarg_pkg::ARGS_W-1:0]  arg_count;

    modport source (output valid, output slash_run, output has_char, output char_out,
                    output end_arg, output end_line, output arg_count, input ready);
    modport sink   (input valid, input slash_run, input has_char, input char_out,
                    input end_arg, input end_line, input arg_count, output ready);
endinterface

FILE: hdl/cmdarg_front.sv
// Front end: accepts characters and classifies them for the queue.
module cmdarg_front (
    cmdarg_in_if.sink          i_in,
    input  logic               i_q_ready,
    output logic               o_q_valid,
    output cmdarg_pkg::t_item  o_q_item
);
    import cmdarg_pkg::*;

    assign i_in.ready = i_q_ready;
    assign o_q_valid  = i_in.valid;

    always_comb begin
        o_q_item.ch       = i_in.ch;
        o_q_item.is_zero  = (i_in.ch == '0);
        o_q_item.is_blank = (i_in.ch == CH_SPACE) || (i_in.ch == CH_TAB);
        o_q_item.is_quote = (i_in.ch == CH_QUOTE);
        o_q_item.is_slash = (i_in.ch == CH_SLASH);
    end
endmodule

FILE: hdl/cmdarg_queue.sv
// Two-entry queue of classified characters between front and back end.
module cmdarg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cmdarg_pkg::t_item  i_item,
    output logic               o_ready,
    output logic               o_valid,
    output cmdarg_pkg::t_item  o_item,
    input  logic               i_pop
);
    import cmdarg_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end
endmodule

FILE: hdl/cmdarg_back.sv
// Back end: splitting state machine and registered result output.
module cmdarg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  cmdarg_pkg::t_item  i_q_item,
    output logic               o_q_pop,
    cmdarg_out_if.source       o_out
);
    import cmdarg_pkg::*;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_qc, n_qc;
    logic               r_iqr, n_iqr;
    logic [SLASH_W-1:0] r_ps, n_ps;
    logic [ARGS_W-1:0]  r_args, n_args;

    logic    r_valid;
    t_result r_res;

    logic    emit;
    logic    later;
    logic    done;
    logic    line_end;
    t_result res;

    logic [1:0]         qc;
    logic               iqr;
    logic [SLASH_W-1:0] ps;
    logic [ARGS_W-1:0]  args_v;

    assign o_q_pop = i_q_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_phase  = r_phase;
        qc       = r_qc;
        iqr      = r_iqr;
        ps       = r_ps;
        args_v   = r_args;
        emit     = 1'b0;
        later    = 1'b0;
        done     = 1'b0;
        line_end = 1'b0;
        res      = '0;

        case (r_phase)
            PH_FIRST_QUOTED, PH_FIRST_PLAIN: begin
                if (i_q_item.is_zero) begin
                    emit         = 1'b1;
                    res.end_arg  = 1'b1;
                    res.end_line = 1'b1;
                    line_end     = 1'b1;
                end else if ((r_phase == PH_FIRST_QUOTED && i_q_item.is_quote) ||
                             (r_phase == PH_FIRST_PLAIN && i_q_item.is_blank)) begin
                    emit        = 1'b1;
                    res.end_arg = 1'b1;
                    n_phase     = PH_BETWEEN;
                end else begin
                    emit         = 1'b1;
                    res.has_char = 1'b1;
                    res.char_out = i_q_item.ch;
                end
            end
            PH_BETWEEN: begin
                if (i_q_item.is_blank) begin
                    emit = 1'b0;
                end else if (i_q_item.is_zero) begin
                    emit         = 1'b1;
                    res.end_line = 1'b1;
                    line_end     = 1'b1;
                end else begin
                    if (r_args < ARG_CAP) begin
                        args_v = r_args + 1'b1;
                    end
                    n_phase = PH_ARG;
                    qc      = 2'd0;
                    iqr     = 1'b0;
                    ps      = '0;
                    later   = 1'b1;
                end
            end
            PH_ARG: begin
                later = 1'b1;
            end
            default: begin
                if (r_args < ARG_CAP) begin
                    args_v = r_args + 1'b1;
                end
                if (i_q_item.is_quote) begin
                    n_phase = PH_FIRST_QUOTED;
                end else if (i_q_item.is_zero) begin
                    emit         = 1'b1;
                    res.end_arg  = 1'b1;
                    res.end_line = 1'b1;
                    line_end     = 1'b1;
                end else if (i_q_item.is_blank) begin
                    emit        = 1'b1;
                    res.end_arg = 1'b1;
                    n_phase     = PH_BETWEEN;
                end else begin
                    emit         = 1'b1;
                    res.has_char = 1'b1;
                    res.char_out = i_q_item.ch;
                    n_phase      = PH_FIRST_PLAIN;
                end
            end
        endcase

        if (later) begin
            if (iqr) begin
                if (i_q_item.is_quote) begin
                    done = 1'b1;
                    if (qc >= QUOTE_LIT) begin
                        qc           = 2'd0;
                        emit         = 1'b1;
                        res.has_char = 1'b1;
                        res.char_out = CH_QUOTE;
                    end else begin
                        qc = qc + 2'd1;
                    end
                end else begin
                    iqr = 1'b0;
                    if (qc == QUOTE_LIT) begin
                        qc = 2'd0;
                    end
                end
            end
            if (!done) begin
                if (i_q_item.is_zero) begin
                    emit          = 1'b1;
                    res.slash_run = ps;
                    res.end_arg   = 1'b1;
                    res.end_line  = 1'b1;
                    line_end      = 1'b1;
                end else if (i_q_item.is_blank && qc == 2'd0) begin
                    emit          = 1'b1;
                    res.slash_run = ps;
                    res.end_arg   = 1'b1;
                    ps            = '0;
                    n_phase       = PH_BETWEEN;
                end else if (i_q_item.is_slash) begin
                    if (ps < SLASH_CAP) begin
                        ps = ps + 1'b1;
                    end
                end else if (i_q_item.is_quote) begin
                    emit          = ps[0] || (ps[SLASH_W-1:1] != '0);
                    res.slash_run = {1'b0, ps[SLASH_W-1:1]};
                    res.has_char  = ps[0];
                    res.char_out  = ps[0] ? CH_QUOTE : '0;
                    if (!ps[0]) begin
                        qc = qc + 2'd1;
                    end
                    ps  = '0;
                    iqr = 1'b1;
                end else begin
                    emit          = 1'b1;
                    res.slash_run = ps;
                    res.has_char  = 1'b1;
                    res.char_out  = i_q_item.ch;
                    ps            = '0;
                end
            end
        end

        res.arg_count = args_v;

        n_qc   = qc;
        n_iqr  = iqr;
        n_ps   = ps;
        n_args = args_v;
        if (line_end) begin
            n_phase = PH_START;
            n_qc    = 2'd0;
            n_iqr   = 1'b0;
            n_ps    = '0;
            n_args  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_qc    <= 2'd0;
            r_iqr   <= 1'b0;
            r_ps    <= '0;
            r_args  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase <= n_phase;
                r_qc    <= n_qc;
                r_iqr   <= n_iqr;
                r_ps    <= n_ps;
                r_args  <= n_args;
            end
            if (o_q_pop && emit) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && emit) begin
            r_res <= res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.slash_run = r_res.slash_run;
    assign o_out.has_char  = r_res.has_char;
    assign o_out.char_out  = r_res.char_out;
    assign o_out.end_arg   = r_res.end_arg;
    assign o_out.end_line  = r_res.end_line;
    assign o_out.arg_count = r_res.arg_count;
endmodule

FILE: hdl/command_line_arg_splitter.sv
// Top level: command-line splitter, front classifier, queue and back end.
// A character's result is registered first in the queue, then in the back end's output register.
// Throughput: one character per cycle while o_out.ready does not stall the back end; its per-character update sets it.
// Characters that give no result are still popped and processed by the back end.
// Reset: synchronous active-low i_rst_n clears queue, phase, counters and output valid.
module command_line_arg_splitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cmdarg_in_if.sink     i_in,
    cmdarg_out_if.source  o_out
);
    import cmdarg_pkg::*;

    logic  front_valid;
    t_item front_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    cmdarg_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_valid (front_valid),
        .o_q_item  (front_item)
    );

    cmdarg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    cmdarg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule

FILE: verif/command_line_arg_splitter_test.sv
// Testbench: command-line splitter checked against a cycle-free predictor, random idling.
module command_line_arg_splitter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cmdarg_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE       = 10;
    localparam int RANDOM_CHARS = 1640;
    localparam int QUIET_TAIL   = 250;

    logic clk;
    logic rst_n;

    cmdarg_in_if  in_if ();
    cmdarg_out_if out_if ();

    command_line_arg_splitter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state
    t_phase             ph;
    logic [1:0]         q_cnt;
    logic               q_run;
    logic [SLASH_W-1:0] slashes;
    logic [ARGS_W-1:0]  args;

    t_result     arg_pieces[$];
    int unsigned chars_sent;
    int unsigned fails;
    bit          idle_on;
    bit          long_hold;
    event        hold_kick;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void line_reset();
        ph      = PH_START;
        q_cnt   = '0;
        q_run   = 1'b0;
        slashes = '0;
        args    = '0;
    endfunction

    function automatic void bump_args();
        if (args < ARG_CAP) args = args + 1'b1;
    endfunction

    function automatic t_result piece(input logic [SLASH_W-1:0] run, input logic has,
                                      input logic [CH_W-1:0] c, input logic ea,
                                      input logic el);
        t_result r;
        r.slash_run = run;
        r.has_char  = has;
        r.char_out  = has ? c : '0;
        r.end_arg   = ea;
        r.end_line  = el;
        r.arg_count = args;
        return r;
    endfunction

    function automatic bit split_char(input logic [CH_W-1:0] c, output t_result r);
        logic               blank;
        logic [SLASH_W-1:0] half;
        logic               odd;
        blank = (c == CH_SPACE) || (c == CH_TAB);
        r = '0;
        case (ph)
            PH_START: begin
                bump_args();
                if (c == CH_QUOTE) begin
                    ph = PH_FIRST_QUOTED;
                    return 1'b0;
                end
                if (c == '0) begin
                    r = piece('0, 1'b0, '0, 1'b1, 1'b1);
                    line_reset();
                    return 1'b1;
                end
                if (blank) begin
                    r = piece('0, 1'b0, '0, 1'b1, 1'b0);
                    ph = PH_BETWEEN;
                    return 1'b1;
                end
                r = piece('0, 1'b1, c, 1'b0, 1'b0);
                ph = PH_FIRST_PLAIN;
                return 1'b1;
            end
            PH_FIRST_QUOTED, PH_FIRST_PLAIN: begin
                if (c == '0) begin
                    r = piece('0, 1'b0, '0, 1'b1, 1'b1);
                    line_reset();
                    return 1'b1;
                end
                if ((ph == PH_FIRST_QUOTED && c == CH_QUOTE) ||
                    (ph == PH_FIRST_PLAIN && blank)) begin
                    r = piece('0, 1'b0, '0, 1'b1, 1'b0);
                    ph = PH_BETWEEN;
                    return 1'b1;
                end
                r = piece('0, 1'b1, c, 1'b0, 1'b0);
                return 1'b1;
            end
            PH_BETWEEN: begin
                if (blank) return 1'b0;
                if (c == '0) begin
                    r = piece('0, 1'b0, '0, 1'b0, 1'b1);
                    line_reset();
                    return 1'b1;
                end
                bump_args();
                ph      = PH_ARG;
                q_cnt   = '0;
                q_run   = 1'b0;
                slashes = '0;
            end
            default: ;
        endcase

        // later arguments
        if (q_run) begin
            if (c == CH_QUOTE) begin
                q_cnt = q_cnt + 1'b1;
                if (q_cnt == 2'd3) begin
                    q_cnt = '0;
                    r = piece('0, 1'b1, CH_QUOTE, 1'b0, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            q_run = 1'b0;
            if (q_cnt == QUOTE_LIT) q_cnt = '0;
        end
        if (c == '0) begin
            r = piece(slashes, 1'b0, '0, 1'b1, 1'b1);
            line_reset();
            return 1'b1;
        end
        if (blank && q_cnt == '0) begin
            r = piece(slashes, 1'b0, '0, 1'b1, 1'b0);
            slashes = '0;
            ph = PH_BETWEEN;
            return 1'b1;
        end
        if (c == CH_SLASH) begin
            if (slashes < SLASH_CAP) slashes = slashes + 1'b1;
            return 1'b0;
        end
        if (c == CH_QUOTE) begin
            half    = slashes >> 1;
            odd     = slashes[0];
            slashes = '0;
            q_run   = 1'b1;
            if (!odd) q_cnt = q_cnt + 1'b1;
            if (odd || half != '0) begin
                r = piece(half, odd, CH_QUOTE, 1'b0, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        r = piece(slashes, 1'b1, c, 1'b0, 1'b0);
        slashes = '0;
        return 1'b1;
    endfunction

    function automatic string show(input t_result p);
        return {$sformatf("slash_run %0d has_char %0b char_out %h ",
                          p.slash_run, p.has_char, p.char_out),
                $sformatf("end_arg %0b end_line %0b arg_count %0d",
                          p.end_arg, p.end_line, p.arg_count)};
    endfunction

    task automatic flag_error(input string msg);
        fails++;
        if (fails <= 10) $display("%t ERROR: %s", $realtime, msg);
    endtask

    task automatic check_piece();
        t_result got;
        t_result want;
        got = '{slash_run: out_if.slash_run, has_char: out_if.has_char,
                char_out: out_if.char_out, end_arg: out_if.end_arg,
                end_line: out_if.end_line, arg_count: out_if.arg_count};
        if (arg_pieces.size() == 0) begin
            flag_error({"unexpected transaction: ", show(got)});
            return;
        end
        want = arg_pieces.pop_front();
        if (got.slash_run !== want.slash_run || got.has_char !== want.has_char ||
            got.char_out !== want.char_out || got.end_arg !== want.end_arg ||
            got.end_line !== want.end_line || got.arg_count !== want.arg_count)
            flag_error({"mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
    endtask

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) check_piece();
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold) begin
                out_if.ready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_if.ready = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(0, 8);
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin : hold_off
        long_hold = 1'b0;
        @(hold_kick);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Entered and left at a falling edge; valid stays high for the next character.
    task automatic send_char(input logic [CH_W-1:0] c);
        t_result r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.ch    = c;
        do @(posedge clk); while (!in_if.ready);
        if (split_char(c, r)) arg_pieces.push_back(r);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]});
    endtask

    function automatic logic [CH_W-1:0] letter();
        return CH_W'(16'h0061 + $urandom_range(0, 25));
    endfunction

    task automatic test_empty_line();
        send_char('0);
        send_char('0);
    endtask

    task automatic test_first_token();
        send_text("\"a b\"c d");
        send_char('0);
        send_text(" x");
        send_char('0);
        send_text("p\tq");
        send_char(16'hFFFF);
        send_char('0);
        send_text("\"ab");
        send_char('0);
    endtask

    task automatic test_escapes();
        send_text("p a\\b \\\\\"c \\\\\\\"d");
        send_char(16'hFFFF);
        send_char(16'h0001);
        send_text(" x\\");
        send_char('0);
    endtask

    task automatic test_quote_runs();
        send_text("p \"\"\"x\"\"\"\" \"a\tb\" \"\"");
        send_char('0);
    endtask

    task automatic test_backpressure();
        -> hold_kick;
        repeat (40) send_char(letter());
        send_char('0);
    endtask

    task automatic send_chunk();
        case ($urandom_range(0, 13))
            0, 1, 2, 3: send_char(letter());
            4:          send_char(CH_SPACE);
            5:          send_char(CH_TAB);
            6:          send_char(CH_QUOTE);
            7:          repeat ($urandom_range(1, 7)) send_char(CH_QUOTE);
            8: begin
                repeat ($urandom_range(1, 6)) send_char(CH_SLASH);
                send_char(CH_QUOTE);
            end
            9: begin
                repeat ($urandom_range(1, 6)) send_char(CH_SLASH);
                send_char(letter());
            end
            10, 11:     send_char(CH_W'($urandom_range(16'hFFFF, 1)));
            12:         send_char(CH_SLASH);
            default:    send_char(CH_W'($urandom));
        endcase
    endtask

    task automatic test_random_lines();
        int unsigned stop_at;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at) begin
            if (chars_sent + QUIET_TAIL >= stop_at) idle_on = 1'b0;
            case ($urandom_range(0, 3))
                0:       send_char(CH_QUOTE);
                1:       send_char(CH_SPACE);
                default: ;
            endcase
            repeat ($urandom_range(0, 30)) send_chunk();
            send_char('0);
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_if.valid = 1'b0;
        in_if.ch    = '0;
        chars_sent  = 0;
        fails       = 0;
        idle_on     = 1'b1;
        line_reset();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_line();
        test_first_token();
        test_escapes();
        test_quote_runs();
        test_backpressure();
        test_random_lines();

        in_if.valid = 1'b0;
        while (arg_pieces.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
